// ===== hdl/lurm_pkg.sv =====
`timescale 1ns / 1ps

package lurm_pkg;

  localparam logic [3:0] REG_FOCAL_X       = 4'd0;
  localparam logic [3:0] REG_FOCAL_Y       = 4'd1;
  localparam logic [3:0] REG_CENTRE_X      = 4'd2;
  localparam logic [3:0] REG_CENTRE_Y      = 4'd3;
  localparam logic [3:0] REG_RADIAL_K1     = 4'd4;
  localparam logic [3:0] REG_RADIAL_K2     = 4'd5;
  localparam logic [3:0] REG_TANGENTIAL_P1 = 4'd6;
  localparam logic [3:0] REG_TANGENTIAL_P2 = 4'd7;

  localparam logic signed [35:0] ONE_Q24 = 36'sh001000000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic        [19:0] focal_x;
    logic        [19:0] focal_y;
    logic        [19:0] centre_x;
    logic        [19:0] centre_y;
    logic signed [31:0] radial_k1;
    logic signed [31:0] radial_k2;
    logic signed [31:0] tangential_p1;
    logic signed [31:0] tangential_p2;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < 64'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/lurm_pix_if.sv =====
`timescale 1ns / 1ps

interface lurm_pix_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_col;
  logic [11:0] out_row;
  modport source(output valid, output out_col, output out_row, input ready);
  modport sink(input valid, input out_col, input out_row, output ready);
endinterface

// ===== hdl/lurm_res_if.sv =====
`timescale 1ns / 1ps

interface lurm_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] src_col;
  logic [11:0] src_row;
  logic        inside_res;
  modport source(output valid, output src_col, output src_row, output inside_res, input ready);
  modport sink(input valid, input src_col, input src_row, input inside_res, output ready);
endinterface

// ===== hdl/lurm_cfg_if.sv =====
`timescale 1ns / 1ps

interface lurm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hdl/lens_undistort_remap_address.sv =====
`timescale 1ns / 1ps

// channel  modport  payload
// pix      sink     out_col, out_row
// res      source   src_col, src_row, inside_res
// cfg      sink     index, data (write only, always ready)
//
// one pixel per clock while res is not stalled; each pixel passes through the
// divider and then the distortion datapath
// rst is synchronous and clears all valid bits and loads default registers
// a stall on res freezes the whole pipeline, nothing is dropped or repeated

module lens_undistort_remap_address #(
  parameter int IMG_COLS = 1024,
  parameter int IMG_ROWS = 1024
) (
  input logic            clk,
  input logic            rst,
  lurm_pix_if.sink       pix,
  lurm_res_if.source     res,
  lurm_cfg_if.sink       cfg
);

  lurm_pkg::cfg_t    regs;
  logic              adv;
  logic              nvalid;
  logic signed [31:0] nx, ny;
  logic              nvalid_y;

  assign adv       = !res.valid || res.ready;
  assign pix.ready = adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.focal_x       <= 20'd117415;
      regs.focal_y       <= 20'd117068;
      regs.centre_x      <= 20'd94007;
      regs.centre_y      <= 20'd63584;
      regs.radial_k1     <= -32'sd304307141;
      regs.radial_k2     <= 32'sd79412947;
      regs.tangential_p1 <= 32'sd207866;
      regs.tangential_p2 <= 32'sd18918;
    end else if (cfg.valid) begin
      case (cfg.index)
        lurm_pkg::REG_FOCAL_X:       regs.focal_x       <= cfg.data[19:0];
        lurm_pkg::REG_FOCAL_Y:       regs.focal_y       <= cfg.data[19:0];
        lurm_pkg::REG_CENTRE_X:      regs.centre_x      <= cfg.data[19:0];
        lurm_pkg::REG_CENTRE_Y:      regs.centre_y      <= cfg.data[19:0];
        lurm_pkg::REG_RADIAL_K1:     regs.radial_k1     <= $signed(cfg.data);
        lurm_pkg::REG_RADIAL_K2:     regs.radial_k2     <= $signed(cfg.data);
        lurm_pkg::REG_TANGENTIAL_P1: regs.tangential_p1 <= $signed(cfg.data);
        lurm_pkg::REG_TANGENTIAL_P2: regs.tangential_p2 <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  lurm_norm u_norm_x (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .vin    (pix.valid),
    .pix    (pix.out_col),
    .centre (regs.centre_x),
    .focal  (regs.focal_x),
    .vout   (nvalid),
    .norm   (nx)
  );

  lurm_norm u_norm_y (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .vin    (pix.valid),
    .pix    (pix.out_row),
    .centre (regs.centre_y),
    .focal  (regs.focal_y),
    .vout   (nvalid_y),
    .norm   (ny)
  );

  lurm_dist #(
    .IMG_COLS (IMG_COLS),
    .IMG_ROWS (IMG_ROWS)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .vin        (nvalid && nvalid_y),
    .x          (nx),
    .y          (ny),
    .cfg        (regs),
    .vout       (res.valid),
    .src_col    (res.src_col),
    .src_row    (res.src_row),
    .inside_res (res.inside_res)
  );

endmodule

// ===== hdl/lurm_norm.sv =====
`timescale 1ns / 1ps

module lurm_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               vin,
  input  logic        [11:0] pix,
  input  logic        [19:0] centre,
  input  logic        [19:0] focal,
  output logic               vout,
  output logic signed [31:0] norm
);

  localparam int Steps = 8;
  localparam int Bits  = 4;

  logic               v    [0:Steps];
  logic               neg  [0:Steps];
  logic               ovf  [0:Steps];
  logic        [20:0] mag  [0:Steps];
  logic        [19:0] fdiv [0:Steps];
  logic        [19:0] rem  [0:Steps];
  logic        [31:0] quo  [0:Steps];

  logic signed [20:0] d0;
  logic        [20:0] mag0;
  logic        [19:0] f0;

  always_comb begin
    d0   = $signed({1'b0, pix, 8'b0}) - $signed({1'b0, centre});
    mag0 = d0[20] ? 21'(-d0) : 21'(d0);
    f0   = (focal == 20'd0) ? 20'd1 : focal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= vin;
    end
    if (adv) begin
      neg[0]  <= d0[20];
      mag[0]  <= mag0;
      fdiv[0] <= f0;
      ovf[0]  <= {6'b0, mag0} >= {f0, 7'b0};
      rem[0]  <= {7'b0, mag0[20:8]};
      quo[0]  <= '0;
    end
  end

  // restoring division, four quotient bits per stage
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [31:0] num;
    logic [20:0] t;
    logic [19:0] r;
    logic [31:0] q;

    always_comb begin
      num = {mag[s][7:0], 24'b0};
      r   = rem[s];
      q   = quo[s];
      t   = '0;
      for (int j = 0; j < Bits; j++) begin
        t = {r, num[31 - (s * Bits + j)]};
        if (t >= {1'b0, fdiv[s]}) begin
          t = t - {1'b0, fdiv[s]};
          q[31 - (s * Bits + j)] = 1'b1;
        end
        r = t[19:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
      if (adv) begin
        neg[s+1]  <= neg[s];
        ovf[s+1]  <= ovf[s];
        mag[s+1]  <= mag[s];
        fdiv[s+1] <= fdiv[s];
        rem[s+1]  <= r;
        quo[s+1]  <= q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= v[Steps];
    end
    if (adv) begin
      if (ovf[Steps]) begin
        norm <= neg[Steps] ? lurm_pkg::S32_MIN : lurm_pkg::S32_MAX;
      end else begin
        norm <= neg[Steps] ? -$signed(quo[Steps]) : $signed(quo[Steps]);
      end
    end
  end

endmodule

// ===== hdl/lurm_dist.sv =====
`timescale 1ns / 1ps

module lurm_dist #(
  parameter int IMG_COLS = 1024,
  parameter int IMG_ROWS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               vin,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  lurm_pkg::cfg_t     cfg,
  output logic               vout,
  output logic        [11:0] src_col,
  output logic        [11:0] src_row,
  output logic               inside_res
);

  localparam int Depth = 10;

  logic v [1:Depth];

  logic signed [63:0] p_xx, p_yy, p_xy;
  logic signed [31:0] x1, y1, x2, y2, x3, y3, x4, y4, x5, y5, x6, y6, x7, y7;
  logic signed [39:0] xx2, yy2, xy2, xy3;
  logic signed [40:0] r2_3;
  logic signed [42:0] tx3, ty3;
  logic signed [63:0] p_r4, p_k1, p_pa, p_pb, p_pc, p_pd;
  logic signed [39:0] r4_5;
  logic signed [33:0] k1r2_5, k1r2_6;
  logic signed [35:0] txd5, tyd5, txd6, tyd6, txd7, tyd7, txd8, tyd8;
  logic signed [63:0] p_k2;
  logic signed [35:0] rad7;
  logic signed [63:0] p_xr, p_yr;
  logic signed [40:0] xd9, yd9;
  logic signed [63:0] p_fx, p_fy;
  logic signed [30:0] sx, sy;
  logic               in_x, in_y;

  always_comb begin
    sx   = 31'($signed(p_fx[63:24])) + 31'($signed({1'b0, cfg.centre_x}));
    sy   = 31'($signed(p_fy[63:24])) + 31'($signed({1'b0, cfg.centre_y}));
    in_x = !sx[30] && (sx[29:0] < 30'(IMG_COLS * 256));
    in_y = !sy[30] && (sy[29:0] < 30'(IMG_ROWS * 256));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= Depth; i++) begin
        v[i] <= 1'b0;
      end
      vout <= 1'b0;
    end else if (adv) begin
      v[1] <= vin;
      for (int i = 2; i <= Depth; i++) begin
        v[i] <= v[i-1];
      end
      vout <= v[Depth];
    end
    if (adv) begin
      p_xx <= x * x;
      p_yy <= y * y;
      p_xy <= x * y;
      x1 <= x;
      y1 <= y;

      xx2 <= $signed(p_xx[63:24]);
      yy2 <= $signed(p_yy[63:24]);
      xy2 <= $signed(p_xy[63:24]);
      x2 <= x1;
      y2 <= y1;

      r2_3 <= 41'(xx2) + 41'(yy2);
      tx3  <= (43'(xx2) <<< 1) + 43'(xx2) + 43'(yy2);
      ty3  <= (43'(yy2) <<< 1) + 43'(yy2) + 43'(xx2);
      xy3  <= xy2;
      x3 <= x2;
      y3 <= y2;

      p_r4 <= lurm_pkg::sat32(64'(r2_3)) * lurm_pkg::sat32(64'(r2_3));
      p_k1 <= cfg.radial_k1 * lurm_pkg::sat32(64'(r2_3));
      p_pa <= cfg.tangential_p1 * lurm_pkg::sat32(64'(xy3));
      p_pb <= cfg.tangential_p2 * lurm_pkg::sat32(64'(tx3));
      p_pc <= cfg.tangential_p1 * lurm_pkg::sat32(64'(ty3));
      p_pd <= cfg.tangential_p2 * lurm_pkg::sat32(64'(xy3));
      x4 <= x3;
      y4 <= y3;

      r4_5   <= $signed(p_r4[63:24]);
      k1r2_5 <= $signed(p_k1[63:30]);
      txd5   <= (36'($signed(p_pa[63:30])) <<< 1) + 36'($signed(p_pb[63:30]));
      tyd5   <= 36'($signed(p_pc[63:30])) + (36'($signed(p_pd[63:30])) <<< 1);
      x5 <= x4;
      y5 <= y4;

      p_k2   <= cfg.radial_k2 * lurm_pkg::sat32(64'(r4_5));
      k1r2_6 <= k1r2_5;
      txd6   <= txd5;
      tyd6   <= tyd5;
      x6 <= x5;
      y6 <= y5;

      rad7 <= lurm_pkg::ONE_Q24 + 36'(k1r2_6) + 36'($signed(p_k2[63:30]));
      txd7 <= txd6;
      tyd7 <= tyd6;
      x7 <= x6;
      y7 <= y6;

      p_xr <= x7 * lurm_pkg::sat32(64'(rad7));
      p_yr <= y7 * lurm_pkg::sat32(64'(rad7));
      txd8 <= txd7;
      tyd8 <= tyd7;

      xd9 <= 41'($signed(p_xr[63:24])) + 41'(txd8);
      yd9 <= 41'($signed(p_yr[63:24])) + 41'(tyd8);

      p_fx <= 64'($signed({1'b0, cfg.focal_x})) * lurm_pkg::sat32(64'(xd9));
      p_fy <= 64'($signed({1'b0, cfg.focal_y})) * lurm_pkg::sat32(64'(yd9));

      inside_res <= in_x && in_y;
      src_col    <= (in_x && in_y) ? sx[19:8] : 12'd0;
      src_row    <= (in_x && in_y) ? sy[19:8] : 12'd0;
    end
  end

endmodule
